>>> sv/sps_pkg.sv
// ---------------------------------------------------------------------------
// sps_pkg: shared types and constants for the pair-sum select block
// Command codes, queue item layout, memory select codes and the control
// structs between the sequencer and the heap sift unit.
// ---------------------------------------------------------------------------
package sps_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int KEEP_DEF    = 1024;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 11;
  localparam int ELEM_W = 32;
  localparam int SUM_W  = 33;
  localparam int LEN_W  = 11;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_BUILD  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] elem;
    logic              slot_ok;
  } item_t;

  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_K = 2'd2
  } mem_sel_t;

  typedef enum logic {
    SIFT_DOWN = 1'b0,
    SIFT_UP   = 1'b1
  } sift_op_t;

  typedef struct packed {
    logic     start;
    sift_op_t op;
  } sift_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sift_sts_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> sv/sps_ifc.sv
// ---------------------------------------------------------------------------
// sps_ifc: valid/ready channels of the pair-sum select block
// Command channel into the block and result channel out of it.
// ---------------------------------------------------------------------------
interface sps_in_if import sps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [POS_W-1:0]  position;
  logic [ELEM_W-1:0] element_value;

  modport source (output valid, output command, output position, output element_value,
                  input ready);
  modport sink (input valid, input command, input position, input element_value,
                output ready);
endinterface

interface sps_out_if import sps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] sum_value;
  logic             status;

  modport source (output valid, output sum_value, output status, input ready);
  modport sink (input valid, input sum_value, input status, output ready);
endinterface

>>> sv/sps_ram.sv
// ---------------------------------------------------------------------------
// sps_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module sps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sps_front.sv
// ---------------------------------------------------------------------------
// sps_front: command intake and queue
// Accepts transactions, classifies them and holds them in a short queue.
// ---------------------------------------------------------------------------
module sps_front import sps_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  sps_in_if.sink in_if,
  output item_t head_o,
  output logic  head_valid_o,
  input  logic  pop_i
);

  item_t           q_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, rptr_r;
  logic [Q_AW:0]   cnt_r;
  item_t           item;
  logic            push;
  logic            pop;

  always_comb begin
    item.cmd  = cmd_t'(in_if.command);
    item.pos  = in_if.position;
    item.elem = in_if.element_value;
    if (item.cmd == CMD_LOAD_A || item.cmd == CMD_LOAD_B) begin
      item.slot_ok = (32'(in_if.position) < MAX_LEN);
    end else begin
      item.slot_ok = (in_if.position != '0);
    end
  end

  assign in_if.ready  = (cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign push         = in_if.valid && in_if.ready;
  assign pop          = pop_i && (cnt_r != '0);
  assign head_valid_o = (cnt_r != '0);
  assign head_o       = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

endmodule

>>> sv/sps_sift.sv
// ---------------------------------------------------------------------------
// sps_sift: max-heap sift unit
// Moves a value down or up a max-heap held in RAM, one compare per step.
// ---------------------------------------------------------------------------
module sps_sift import sps_pkg::*; #(
  parameter int IW = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sift_ctl_t        ctl_i,
  input  logic [IW-1:0]    n_i,
  input  logic [IW-1:0]    idx_i,
  input  logic [SUM_W-1:0] val_i,
  output sift_sts_t        sts_o,
  output logic [IW-1:0]    raddr_o,
  output logic [IW-1:0]    waddr_o,
  output logic             we_o,
  output logic [SUM_W-1:0] wdata_o,
  input  logic [SUM_W-1:0] rdata_i
);

  typedef enum logic [6:0] {
    SF_IDLE    = 7'b0000001,
    SF_SD_TEST = 7'b0000010,
    SF_SD_L    = 7'b0000100,
    SF_SD_R    = 7'b0001000,
    SF_SD_CMP  = 7'b0010000,
    SF_SU_TEST = 7'b0100000,
    SF_SU_CMP  = 7'b1000000
  } sf_state_t;

  sf_state_t        state_r, state_nxt;
  logic [IW-1:0]    n_r, n_nxt;
  logic [IW-1:0]    i_r, i_nxt;
  logic [IW-1:0]    p_r, p_nxt;
  logic [SUM_W-1:0] v_r, v_nxt;
  logic [SUM_W-1:0] vl_r, vl_nxt;
  logic [SUM_W-1:0] vr_r, vr_nxt;
  logic             hasr_r, hasr_nxt;
  logic [IW:0]      lft, rgt;
  logic             pick_r;
  logic [SUM_W-1:0] vc;
  logic [IW-1:0]    im1;

  assign lft    = {i_r, 1'b1};
  assign rgt    = lft + (IW+1)'(1);
  assign pick_r = hasr_r && (vr_r > vl_r);
  assign vc     = pick_r ? vr_r : vl_r;
  assign im1    = i_r - 1'b1;

  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    p_nxt      = p_r;
    v_nxt      = v_r;
    vl_nxt     = vl_r;
    vr_nxt     = vr_r;
    hasr_nxt   = hasr_r;
    raddr_o    = '0;
    waddr_o    = i_r;
    we_o       = 1'b0;
    wdata_o    = v_r;
    sts_o.busy = (state_r != SF_IDLE);
    sts_o.done = 1'b0;
    unique case (state_r)
      SF_IDLE: begin
        if (ctl_i.start) begin
          n_nxt     = n_i;
          i_nxt     = idx_i;
          v_nxt     = val_i;
          state_nxt = (ctl_i.op == SIFT_DOWN) ? SF_SD_TEST : SF_SU_TEST;
        end
      end
      SF_SD_TEST: begin
        if (lft >= {1'b0, n_r}) begin
          we_o       = 1'b1;
          sts_o.done = 1'b1;
          state_nxt  = SF_IDLE;
        end else begin
          raddr_o   = lft[IW-1:0];
          state_nxt = SF_SD_L;
        end
      end
      SF_SD_L: begin
        vl_nxt = rdata_i;
        if (rgt < {1'b0, n_r}) begin
          raddr_o   = rgt[IW-1:0];
          hasr_nxt  = 1'b1;
          state_nxt = SF_SD_R;
        end else begin
          hasr_nxt  = 1'b0;
          state_nxt = SF_SD_CMP;
        end
      end
      SF_SD_R: begin
        vr_nxt    = rdata_i;
        state_nxt = SF_SD_CMP;
      end
      SF_SD_CMP: begin
        we_o = 1'b1;
        if (vc <= v_r) begin
          sts_o.done = 1'b1;
          state_nxt  = SF_IDLE;
        end else begin
          // The larger child moves up into the hole; the hole moves down.
          wdata_o   = vc;
          i_nxt     = pick_r ? rgt[IW-1:0] : lft[IW-1:0];
          state_nxt = SF_SD_TEST;
        end
      end
      SF_SU_TEST: begin
        if (i_r == '0) begin
          we_o       = 1'b1;
          sts_o.done = 1'b1;
          state_nxt  = SF_IDLE;
        end else begin
          p_nxt     = im1 >> 1;
          raddr_o   = im1 >> 1;
          state_nxt = SF_SU_CMP;
        end
      end
      SF_SU_CMP: begin
        we_o = 1'b1;
        if (rdata_i >= v_r) begin
          sts_o.done = 1'b1;
          state_nxt  = SF_IDLE;
        end else begin
          wdata_o   = rdata_i;
          i_nxt     = p_r;
          state_nxt = SF_SU_TEST;
        end
      end
      default: begin
        state_nxt = SF_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SF_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    p_r    <= p_nxt;
    v_r    <= v_nxt;
    vl_r   <= vl_nxt;
    vr_r   <= vr_nxt;
    hasr_r <= hasr_nxt;
  end

endmodule

>>> sv/sps_back.sv
// ---------------------------------------------------------------------------
// sps_back: command execution sequencer
// Carries out loads, queries and the build (two heap sorts, the pair walk
// with a bounded max-heap, and the final heap sort of the kept sums).
// ---------------------------------------------------------------------------
module sps_back import sps_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int KEEP    = KEEP_DEF,
  localparam int IW = $clog2(max_int(MAX_LEN, KEEP) + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  item_t            head_i,
  input  logic             head_valid_i,
  output logic             pop_o,
  sps_out_if.source        out_if,
  output sift_ctl_t        sift_ctl_o,
  output logic [IW-1:0]    sift_n_o,
  output logic [IW-1:0]    sift_idx_o,
  output logic [SUM_W-1:0] sift_val_o,
  input  sift_sts_t        sift_sts_i,
  input  logic [IW-1:0]    sift_raddr_i,
  input  logic [IW-1:0]    sift_waddr_i,
  input  logic             sift_we_i,
  input  logic [SUM_W-1:0] sift_wdata_i,
  output logic [SUM_W-1:0] rdata_o,
  output mem_sel_t         mem_sel_o,
  output logic [IW-1:0]    mem_raddr_o,
  output logic [IW-1:0]    mem_waddr_o,
  output logic             mem_we_o,
  output logic [SUM_W-1:0] mem_wdata_o,
  input  logic [ELEM_W-1:0] rd_a_i,
  input  logic [ELEM_W-1:0] rd_b_i,
  input  logic [SUM_W-1:0]  rd_k_i
);

  typedef enum logic [17:0] {
    ST_IDLE    = 18'h00001,
    ST_Q_RD    = 18'h00002,
    ST_HS_INIT = 18'h00004,
    ST_HZ_CHK  = 18'h00008,
    ST_HZ_RD   = 18'h00010,
    ST_HZ_WAIT = 18'h00020,
    ST_HX_CHK  = 18'h00040,
    ST_HX_RD0  = 18'h00080,
    ST_HX_RD1  = 18'h00100,
    ST_HX_WAIT = 18'h00200,
    ST_PW_INIT = 18'h00400,
    ST_PW_ROW  = 18'h00800,
    ST_PW_AI   = 18'h01000,
    ST_PW_COL  = 18'h02000,
    ST_PW_BJ   = 18'h04000,
    ST_PW_ACT  = 18'h08000,
    ST_PW_WAIT = 18'h10000,
    ST_B_OUT   = 18'h20000
  } st_t;

  st_t               state_r, state_nxt;
  mem_sel_t          sel_r, sel_nxt;
  mem_sel_t          rsel_q_r;
  logic [LEN_W-1:0]  len_r;
  logic              built_r, built_nxt;
  logic [IW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     n_r, n_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [IW-1:0]     j_r, j_nxt;
  logic [SUM_W-1:0]  t_r, t_nxt;
  logic [ELEM_W-1:0] ai_r, ai_nxt;
  logic [SUM_W-1:0]  s_r, s_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_sum_r, out_sum_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_free;
  logic              in_wait;
  logic [IW-1:0]     sort_sz;
  logic [IW-1:0]     n_sat;
  logic [31:0]       pos32;
  logic              rank_ok;

  always_comb begin
    case (rsel_q_r)
      SEL_A:   rdata_o = {1'b0, rd_a_i};
      SEL_B:   rdata_o = {1'b0, rd_b_i};
      default: rdata_o = rd_k_i;
    endcase
  end

  assign out_free = !out_valid_r || out_if.ready;
  assign in_wait  = (state_r == ST_HZ_WAIT) || (state_r == ST_HX_WAIT) ||
                    (state_r == ST_PW_WAIT);
  assign sort_sz  = (sel_r == SEL_K) ? count_r : n_r;
  assign n_sat    = (32'(len_r) > MAX_LEN) ? IW'(MAX_LEN) : IW'(len_r);
  assign pos32    = 32'(head_i.pos);
  assign rank_ok  = built_r && head_i.slot_ok && (pos32 <= 32'(count_r)) &&
                    (pos32 <= KEEP);

  assign out_if.valid     = out_valid_r;
  assign out_if.sum_value = out_sum_r;
  assign out_if.status    = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    sel_nxt        = sel_r;
    built_nxt      = built_r;
    count_nxt      = count_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    t_nxt          = t_r;
    ai_nxt         = ai_r;
    s_nxt          = s_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_sum_nxt    = out_sum_r;
    out_status_nxt = out_status_r;
    pop_o          = 1'b0;
    sift_ctl_o     = '{start: 1'b0, op: SIFT_DOWN};
    sift_n_o       = sort_sz;
    sift_idx_o     = '0;
    sift_val_o     = rdata_o;
    mem_sel_o      = sel_r;
    mem_raddr_o    = '0;
    mem_waddr_o    = '0;
    mem_we_o       = 1'b0;
    mem_wdata_o    = '0;

    if (in_wait) begin
      mem_raddr_o = sift_raddr_i;
      mem_waddr_o = sift_waddr_i;
      mem_we_o    = sift_we_i;
      mem_wdata_o = sift_wdata_i;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (head_valid_i && out_free) begin
          pop_o = 1'b1;
          unique case (head_i.cmd) inside
            CMD_LOAD_A, CMD_LOAD_B: begin
              mem_sel_o      = (head_i.cmd == CMD_LOAD_A) ? SEL_A : SEL_B;
              mem_we_o       = head_i.slot_ok;
              mem_waddr_o    = IW'(pos32);
              mem_wdata_o    = {1'b0, head_i.elem};
              out_valid_nxt  = 1'b1;
              out_sum_nxt    = '0;
              out_status_nxt = 1'b0;
            end
            CMD_BUILD: begin
              n_nxt     = n_sat;
              sel_nxt   = SEL_A;
              state_nxt = ST_HS_INIT;
            end
            default: begin
              if (rank_ok) begin
                mem_sel_o   = SEL_K;
                mem_raddr_o = IW'(pos32 - 32'd1);
                state_nxt   = ST_Q_RD;
              end else begin
                out_valid_nxt  = 1'b1;
                out_sum_nxt    = '0;
                out_status_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      ST_Q_RD: begin
        out_valid_nxt  = 1'b1;
        out_sum_nxt    = rdata_o;
        out_status_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end
      ST_HS_INIT: begin
        k_nxt     = sort_sz >> 1;
        state_nxt = ST_HZ_CHK;
      end
      ST_HZ_CHK: begin
        if (k_r == '0) begin
          k_nxt     = sort_sz;
          state_nxt = ST_HX_CHK;
        end else begin
          mem_raddr_o = k_r - 1'b1;
          state_nxt   = ST_HZ_RD;
        end
      end
      ST_HZ_RD: begin
        sift_ctl_o = '{start: 1'b1, op: SIFT_DOWN};
        sift_idx_o = k_r - 1'b1;
        state_nxt  = ST_HZ_WAIT;
      end
      ST_HZ_WAIT: begin
        if (sift_sts_i.done) begin
          k_nxt     = k_r - 1'b1;
          state_nxt = ST_HZ_CHK;
        end
      end
      ST_HX_CHK: begin
        if (k_r <= IW'(1)) begin
          case (sel_r)
            SEL_A: begin
              sel_nxt   = SEL_B;
              state_nxt = ST_HS_INIT;
            end
            SEL_B: begin
              state_nxt = ST_PW_INIT;
            end
            default: begin
              built_nxt = 1'b1;
              state_nxt = ST_B_OUT;
            end
          endcase
        end else begin
          mem_raddr_o = '0;
          state_nxt   = ST_HX_RD0;
        end
      end
      ST_HX_RD0: begin
        t_nxt       = rdata_o;
        mem_raddr_o = k_r - 1'b1;
        state_nxt   = ST_HX_RD1;
      end
      ST_HX_RD1: begin
        // The current maximum goes to the end; the last leaf is sifted from the root.
        mem_we_o    = 1'b1;
        mem_waddr_o = k_r - 1'b1;
        mem_wdata_o = t_r;
        sift_ctl_o  = '{start: 1'b1, op: SIFT_DOWN};
        sift_n_o    = k_r - 1'b1;
        sift_idx_o  = '0;
        state_nxt   = ST_HX_WAIT;
      end
      ST_HX_WAIT: begin
        if (sift_sts_i.done) begin
          k_nxt     = k_r - 1'b1;
          state_nxt = ST_HX_CHK;
        end
      end
      ST_PW_INIT: begin
        i_nxt     = '0;
        count_nxt = '0;
        sel_nxt   = SEL_K;
        state_nxt = ST_PW_ROW;
      end
      ST_PW_ROW: begin
        if (i_r == n_r) begin
          state_nxt = ST_HS_INIT;
        end else begin
          mem_sel_o   = SEL_A;
          mem_raddr_o = i_r;
          state_nxt   = ST_PW_AI;
        end
      end
      ST_PW_AI: begin
        ai_nxt    = rdata_o[ELEM_W-1:0];
        j_nxt     = '0;
        state_nxt = ST_PW_COL;
      end
      ST_PW_COL: begin
        if (j_r == n_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_PW_ROW;
        end else begin
          mem_sel_o   = SEL_B;
          mem_raddr_o = j_r;
          state_nxt   = ST_PW_BJ;
        end
      end
      ST_PW_BJ: begin
        s_nxt       = {1'b0, ai_r} + {1'b0, rdata_o[ELEM_W-1:0]};
        mem_sel_o   = SEL_K;
        mem_raddr_o = '0;
        state_nxt   = ST_PW_ACT;
      end
      ST_PW_ACT: begin
        sift_val_o = s_r;
        if (32'(count_r) < KEEP) begin
          sift_ctl_o = '{start: 1'b1, op: SIFT_UP};
          sift_idx_o = count_r;
          count_nxt  = count_r + 1'b1;
          state_nxt  = ST_PW_WAIT;
        end else if (s_r < rdata_o) begin
          sift_ctl_o = '{start: 1'b1, op: SIFT_DOWN};
          sift_n_o   = count_r;
          sift_idx_o = '0;
          state_nxt  = ST_PW_WAIT;
        end else begin
          // The rest of this row cannot beat the heap top.
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_PW_ROW;
        end
      end
      ST_PW_WAIT: begin
        if (sift_sts_i.done) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_PW_COL;
        end
      end
      ST_B_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sum_nxt    = '0;
          out_status_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= SEL_A;
      len_r       <= LEN_W'(1);
      built_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      built_r     <= built_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsel_q_r     <= mem_sel_o;
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    t_r          <= t_nxt;
    ai_r         <= ai_nxt;
    s_r          <= s_nxt;
    out_sum_r    <= out_sum_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= KEEP)
    else $error("kept count exceeds heap capacity");

  a_sift_owner: assert property (@(posedge clk) disable iff (!rst_n)
    sift_sts_i.busy |-> in_wait)
    else $error("sift unit busy while sequencer owns the memory port");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |-> head_valid_i)
    else $error("queue popped while empty");

  a_query_built: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q_RD) |-> (built_r && !$past(out_valid_r && !out_if.ready)))
    else $error("query read without a build or with the result slot taken");
`endif

endmodule

>>> sv/smallest_pair_sums_select.sv
// ---------------------------------------------------------------------------
// smallest_pair_sums_select: k smallest pair sums with rank query
// Top level: command queue, execution sequencer, sift unit and three RAMs.
// ---------------------------------------------------------------------------
// Usage: commands enter on in_if (valid/ready); every accepted transaction
// yields exactly one transaction on out_if. Load A/B writes element_value at
// position (slots at or above MAX_LEN are dropped) and answers zero. Build
// heap-sorts both arrays over length_in_use (capped at MAX_LEN) elements,
// walks the pairs into a max-heap of KEEP sums and sorts the kept sums; it
// answers zero when done. Query returns the sum at 1-based rank position,
// or status 1 when the rank is zero, above the kept count, or no build has
// happened. Loads are answered back to back while out_if.ready stays high;
// a query holds the back end for the registered read of the kept-sum RAM.
// A build is bound by the single read port of each RAM and the one sift
// unit. A four-entry queue lets commands be accepted while the back end is
// busy or the result register waits. If out_if.ready is low, the result is
// held, no further command is taken from the queue and in_if.ready drops
// once the queue fills. Synchronous reset (rst_n low) empties the queue,
// clears the built flag and kept count and sets length_in_use to 1.
// cfg_we writes length_in_use; the user must write it only when idle, as
// the block itself does not enforce this.
// ---------------------------------------------------------------------------
module smallest_pair_sums_select import sps_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int KEEP    = KEEP_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  sps_in_if.sink           in_if,
  sps_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  localparam int IW  = $clog2(max_int(MAX_LEN, KEEP) + 1);
  localparam int AAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int KAW = (KEEP > 1) ? $clog2(KEEP) : 1;

  item_t             head;
  logic              head_valid;
  logic              pop;
  sift_ctl_t         sift_ctl;
  sift_sts_t         sift_sts;
  logic [IW-1:0]     sift_n, sift_idx, sift_raddr, sift_waddr;
  logic [SUM_W-1:0]  sift_val, sift_wdata;
  logic              sift_we;
  logic [SUM_W-1:0]  rdata;
  mem_sel_t          mem_sel;
  logic [IW-1:0]     mem_raddr, mem_waddr;
  logic              mem_we;
  logic [SUM_W-1:0]  mem_wdata;
  logic [ELEM_W-1:0] rd_a, rd_b;
  logic [SUM_W-1:0]  rd_k;

  sps_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_if        (in_if),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  sps_sift #(.IW(IW)) u_sift (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (sift_ctl),
    .n_i     (sift_n),
    .idx_i   (sift_idx),
    .val_i   (sift_val),
    .sts_o   (sift_sts),
    .raddr_o (sift_raddr),
    .waddr_o (sift_waddr),
    .we_o    (sift_we),
    .wdata_o (sift_wdata),
    .rdata_i (rdata)
  );

  sps_back #(.MAX_LEN(MAX_LEN), .KEEP(KEEP)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_if       (out_if),
    .sift_ctl_o   (sift_ctl),
    .sift_n_o     (sift_n),
    .sift_idx_o   (sift_idx),
    .sift_val_o   (sift_val),
    .sift_sts_i   (sift_sts),
    .sift_raddr_i (sift_raddr),
    .sift_waddr_i (sift_waddr),
    .sift_we_i    (sift_we),
    .sift_wdata_i (sift_wdata),
    .rdata_o      (rdata),
    .mem_sel_o    (mem_sel),
    .mem_raddr_o  (mem_raddr),
    .mem_waddr_o  (mem_waddr),
    .mem_we_o     (mem_we),
    .mem_wdata_o  (mem_wdata),
    .rd_a_i       (rd_a),
    .rd_b_i       (rd_b),
    .rd_k_i       (rd_k)
  );

  sps_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LEN)) u_ram_a (
    .clk   (clk),
    .we    (mem_we && (mem_sel == SEL_A)),
    .waddr (mem_waddr[AAW-1:0]),
    .wdata (mem_wdata[ELEM_W-1:0]),
    .raddr (mem_raddr[AAW-1:0]),
    .rdata (rd_a)
  );

  sps_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LEN)) u_ram_b (
    .clk   (clk),
    .we    (mem_we && (mem_sel == SEL_B)),
    .waddr (mem_waddr[AAW-1:0]),
    .wdata (mem_wdata[ELEM_W-1:0]),
    .raddr (mem_raddr[AAW-1:0]),
    .rdata (rd_b)
  );

  sps_ram #(.WIDTH(SUM_W), .DEPTH(KEEP)) u_ram_k (
    .clk   (clk),
    .we    (mem_we && (mem_sel == SEL_K)),
    .waddr (mem_waddr[KAW-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr[KAW-1:0]),
    .rdata (rd_k)
  );

endmodule
